### src/sll_pkg.sv
package sll_pkg;

  // Geometry of the link and value stores
  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int POS_W   = 4;
  localparam int VAL_W   = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_UPDATE = 2'd1,
    OP_DELETE = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_PAST_END   = 2'd1,
    ST_NO_FREE    = 2'd2,
    ST_NO_ELEMENT = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WALK_RD,
    S_WALK_LD,
    S_DECIDE,
    S_INS_FREE,
    S_INS_LINK,
    S_INS_SPLICE,
    S_DEL_LINK,
    S_DEL_FREE,
    S_DEL_PUSH,
    S_SLOT,
    S_DONE
  } state_e;

  // One request to the link store: a read and a write port
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] wr_data;
  } link_req_t;

  // Link held by an entry that was never written: i+1, the last entry ends the chain
  function automatic logic [IDX_W-1:0] link_reset(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] nxt;
    nxt = idx + IDX_W'(1);
    if (idx == IDX_W'(ENTRIES - 1)) begin
      nxt = '0;
    end
    return nxt;
  endfunction

endpackage

### src/sll_link_mem.sv
module sll_link_mem
  import sll_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  link_req_t        req_i,
  output logic [IDX_W-1:0] rd_data_o
);

  logic [IDX_W-1:0] mem_q [ENTRIES];
  logic [ENTRIES-1:0] vld_q;
  logic [IDX_W-1:0] rd_data_q;
  logic [IDX_W-1:0] rd_addr_q;
  logic             rd_vld_q;

  // Write the array and read it through a registered port
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
      rd_addr_q <= req_i.rd_addr;
    end
  end

  // Mark entries once written; reset makes every entry read its initial link
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[req_i.rd_addr];
      end
    end
  end

  // Substitute the initial link for an entry never written
  assign rd_data_o = rd_vld_q ? rd_data_q : link_reset(rd_addr_q);

endmodule

### src/static_linked_list_engine_top.sv
// Static linked list engine.
// A singly linked list of 32-bit values lives in ENTRIES fixed entries; entry 0
// heads the free list and an internal register heads the data list.
// Input channel (in_valid_i / in_stall_o): op_i, position_i, value_i. A
// transaction is taken when in_valid_i is high and in_stall_o low. op_i selects
// insert, update or delete at zero-based position_i; op code 3 does nothing.
// Output channel (out_valid_o / out_stall_i): one status_o per request:
// ok, position past list end, no free entry, or no element at the position.
// The block serves one request at a time. It walks the links one registered
// read of the link store at a time, then splices with single-entry accesses.
// Insert and delete take longer than update, and the walk grows with
// position_i; op code 3 skips the walk and the splice.
// A finished status sits in an output register; the next request is taken
// while it waits, but that request cannot finish until the status is taken.
// While out_stall_i is high, a pending status_o and out_valid_o hold.
// After reset the data list is empty and entries 1 to ENTRIES-1 sit on the free
// list in index order; reset takes effect at once, with no clearing pass.
module static_linked_list_engine_top
  import sll_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              op_i,
  input  logic [POS_W-1:0]        position_i,
  input  logic signed [VAL_W-1:0] value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [1:0]              status_o
);

  state_e state_q, state_d;

  op_e                     op_q;
  logic [POS_W-1:0]        pos_q;
  logic signed [VAL_W-1:0] val_q;

  logic [IDX_W-1:0] target_q, target_d;
  logic [IDX_W-1:0] prev_q, prev_d;
  logic             at_head_q, at_head_d;
  logic [POS_W-1:0] steps_q, steps_d;
  logic [IDX_W-1:0] slot_val_q, slot_val_d;
  logic [IDX_W-1:0] fresh_q, fresh_d;
  logic [IDX_W-1:0] head_q, head_d;
  status_e          status_q, status_d;
  logic             out_valid_q, out_valid_d;
  status_e          out_status_q;

  link_req_t        lreq;
  logic [IDX_W-1:0] link_rd;
  logic             val_wr_en;
  logic [IDX_W-1:0] val_wr_addr;
  logic             accept;
  logic             out_load;

  logic signed [VAL_W-1:0] value_mem [ENTRIES];

  assign accept   = in_valid_i && !in_stall_o;
  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  sll_link_mem u_link_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (lreq),
    .rd_data_o (link_rd)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (op_e'(op_i) == OP_NOP) ? S_DONE : S_WALK_RD;
        end
      end
      S_WALK_RD: begin
        if (steps_q == pos_q || target_q == '0) begin
          state_d = S_DECIDE;
        end else begin
          state_d = S_WALK_LD;
        end
      end
      S_WALK_LD: state_d = S_WALK_RD;
      S_DECIDE: begin
        if (steps_q != pos_q) begin
          state_d = S_DONE;
        end else if (op_q == OP_INSERT) begin
          state_d = S_INS_FREE;
        end else if (target_q == '0 || op_q == OP_UPDATE) begin
          state_d = S_DONE;
        end else begin
          state_d = S_DEL_LINK;
        end
      end
      S_INS_FREE:   state_d = (link_rd == '0) ? S_DONE : S_INS_LINK;
      S_INS_LINK:   state_d = S_INS_SPLICE;
      S_INS_SPLICE: state_d = S_SLOT;
      S_DEL_LINK:   state_d = S_DEL_FREE;
      S_DEL_FREE:   state_d = S_DEL_PUSH;
      S_DEL_PUSH:   state_d = S_SLOT;
      S_SLOT:       state_d = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and store accesses per state
  always_comb begin
    target_d    = target_q;
    prev_d      = prev_q;
    at_head_d   = at_head_q;
    steps_d     = steps_q;
    slot_val_d  = slot_val_q;
    fresh_d     = fresh_q;
    head_d      = head_q;
    status_d    = status_q;
    lreq        = '0;
    val_wr_en   = 1'b0;
    val_wr_addr = target_q;
    case (state_q)
      S_IDLE: begin
        target_d  = head_q;
        prev_d    = '0;
        at_head_d = 1'b1;
        steps_d   = '0;
        status_d  = ST_OK;
      end
      S_WALK_RD: begin
        // Step to the next entry unless the position or the end is reached
        if (steps_q != pos_q && target_q != '0) begin
          lreq.rd_en   = 1'b1;
          lreq.rd_addr = target_q;
          prev_d       = target_q;
          at_head_d    = 1'b0;
          steps_d      = steps_q + POS_W'(1);
        end
      end
      S_WALK_LD: target_d = link_rd;
      S_DECIDE: begin
        if (steps_q != pos_q) begin
          status_d = ST_PAST_END;
        end else if (op_q == OP_INSERT) begin
          lreq.rd_en   = 1'b1;
          lreq.rd_addr = '0;
        end else if (target_q == '0) begin
          status_d = ST_NO_ELEMENT;
        end else if (op_q == OP_UPDATE) begin
          val_wr_en = 1'b1;
        end else begin
          lreq.rd_en   = 1'b1;
          lreq.rd_addr = target_q;
        end
      end
      S_INS_FREE: begin
        // Take the first free entry and fetch its successor
        fresh_d = link_rd;
        if (link_rd == '0) begin
          status_d = ST_NO_FREE;
        end else begin
          lreq.rd_en   = 1'b1;
          lreq.rd_addr = link_rd;
        end
      end
      S_INS_LINK: begin
        lreq.wr_en   = 1'b1;
        lreq.wr_addr = '0;
        lreq.wr_data = link_rd;
      end
      S_INS_SPLICE: begin
        lreq.wr_en   = 1'b1;
        lreq.wr_addr = fresh_q;
        lreq.wr_data = target_q;
        val_wr_en    = 1'b1;
        val_wr_addr  = fresh_q;
        slot_val_d   = fresh_q;
      end
      S_DEL_LINK: begin
        // Hold the successor for the slot, then fetch the free list head
        slot_val_d   = link_rd;
        lreq.rd_en   = 1'b1;
        lreq.rd_addr = '0;
      end
      S_DEL_FREE: begin
        lreq.wr_en   = 1'b1;
        lreq.wr_addr = target_q;
        lreq.wr_data = link_rd;
      end
      S_DEL_PUSH: begin
        lreq.wr_en   = 1'b1;
        lreq.wr_addr = '0;
        lreq.wr_data = target_q;
      end
      S_SLOT: begin
        if (at_head_q) begin
          head_d = slot_val_q;
        end else begin
          lreq.wr_en   = 1'b1;
          lreq.wr_addr = prev_q;
          lreq.wr_data = slot_val_q;
        end
      end
      S_DONE: ;
      default: ;
    endcase
  end

  // Output register: load on completion, drop once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_e'(op_i);
      pos_q <= position_i;
      val_q <= value_i;
    end
    target_q   <= target_d;
    prev_q     <= prev_d;
    at_head_q  <= at_head_d;
    steps_q    <= steps_d;
    slot_val_q <= slot_val_d;
    fresh_q    <= fresh_d;
    status_q   <= status_d;
    if (out_load) begin
      out_status_q <= status_q;
    end
  end

  // Value store
  always_ff @(posedge clk_i) begin
    if (val_wr_en) begin
      value_mem[val_wr_addr] <= val_q;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;

  // Never read and write the link store in the same cycle
  a_link_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(lreq.rd_en && lreq.wr_en))
    else $error("link store read and write collide");

  // The walk never overshoots the requested position
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK_RD) |-> (steps_q <= pos_q))
    else $error("walk went past the requested position");

  // A past-end status only when the walk fell short
  a_past_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && status_q == ST_PAST_END) |-> (steps_q != pos_q))
    else $error("past-end status with a complete walk");

  // An insert only splices a nonzero free entry
  a_fresh_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS_SPLICE) |-> (fresh_q != '0))
    else $error("splice of the free list head entry");

  // The data list head always names a real entry
  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(head_q) < ENTRIES))
    else $error("list head out of range");

endmodule

### tb/static_linked_list_engine_top_test.sv
module static_linked_list_engine_top_test;
  import sll_pkg::*;

  typedef struct {
    op_e              op;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
  } list_req_t;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_stall_o;
  logic [1:0]              op_i        = '0;
  logic [POS_W-1:0]        position_i  = '0;
  logic signed [VAL_W-1:0] value_i     = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [1:0]              status_o;

  // Requests waiting to be driven and statuses waiting to come back
  list_req_t pending_req_q[$];
  status_e   due_status_q[$];
  list_req_t next_req;
  status_e   want_status;

  // Shadow of the list: links, values, head and current length
  logic [IDX_W-1:0] link_mem[ENTRIES];
  logic [VAL_W-1:0] value_mem[ENTRIES];
  logic [IDX_W-1:0] head_idx;
  int               list_len;
  int               list_len_peak;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left     = 0;
  bit hold_kick     = 1'b0;
  int gen_len       = 0;
  int items_queued  = 0;
  int items_taken   = 0;
  int results_seen  = 0;
  int error_count   = 0;
  int status_count[4];

  static_linked_list_engine_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .position_i  (position_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o)
  );

  always #4 clk_i = ~clk_i;

  // Walk the shadow list to the position, then apply the request to it
  function automatic status_e apply_list_request(op_e op, logic [POS_W-1:0] pos,
                                                 logic [VAL_W-1:0] val);
    logic [IDX_W-1:0] prev;
    logic [IDX_W-1:0] cur;
    logic [IDX_W-1:0] fresh;
    bit               at_head;
    int               steps;
    if (op == OP_NOP) return ST_OK;
    at_head = 1'b1;
    prev    = '0;
    steps   = 0;
    cur     = head_idx;
    while (steps < pos && cur != '0) begin
      at_head = 1'b0;
      prev    = cur;
      cur     = link_mem[prev];
      steps++;
    end
    if (steps != pos) return ST_PAST_END;
    if (op == OP_INSERT) begin
      fresh = link_mem[0];
      if (fresh == '0) return ST_NO_FREE;
      link_mem[0]      = link_mem[fresh];
      link_mem[fresh]  = cur;
      value_mem[fresh] = val;
      if (at_head) head_idx = fresh;
      else link_mem[prev] = fresh;
      list_len++;
      if (list_len > list_len_peak) list_len_peak = list_len;
      return ST_OK;
    end
    if (cur == '0) return ST_NO_ELEMENT;
    if (op == OP_UPDATE) begin
      value_mem[cur] = val;
    end else begin
      // Unlink the entry and push it onto the front of the free list
      if (at_head) head_idx = link_mem[cur];
      else link_mem[prev] = link_mem[cur];
      link_mem[cur] = link_mem[0];
      link_mem[0]   = cur;
      list_len--;
    end
    return ST_OK;
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < 20) $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Queue one request and track the list length it leads to
  task automatic push_request(input op_e op, input int pos, input logic [VAL_W-1:0] val);
    list_req_t req;
    req.op  = op;
    req.pos = POS_W'(pos);
    req.val = val;
    if (op == OP_INSERT && pos <= gen_len && gen_len < ENTRIES - 1) gen_len++;
    if (op == OP_DELETE && pos < gen_len) gen_len--;
    while (pending_req_q.size() > 8) @(negedge clk_i);
    pending_req_q.push_back(req);
    items_queued++;
  endtask

  // Random request, biased towards growing or shrinking the list
  task automatic push_random(input bit grow);
    int  r;
    int  pos;
    op_e op;
    r = $urandom_range(0, 99);
    if (grow) op = (r < 55) ? OP_INSERT : (r < 75) ? OP_UPDATE : (r < 93) ? OP_DELETE : OP_NOP;
    else      op = (r < 15) ? OP_INSERT : (r < 35) ? OP_UPDATE : (r < 95) ? OP_DELETE : OP_NOP;
    if ($urandom_range(0, 99) < 85) pos = $urandom_range(0, gen_len);
    else pos = $urandom_range(0, 15);
    push_request(op, pos, $urandom);
  endtask

  task automatic run_random(input int n, input bit do_hold);
    int left;
    int burst;
    bit grow;
    bit held;
    left = n;
    grow = 1'b1;
    held = 1'b0;
    while (left > 0) begin
      burst = $urandom_range(20, 60);
      if (burst > left) burst = left;
      repeat (burst) push_random(grow);
      left -= burst;
      grow = !grow;
      // Hold off the receiver for a long stretch while requests keep coming
      if (do_hold && !held && left <= n / 2) begin
        held      = 1'b1;
        hold_kick = 1'b1;
        while (hold_left == 0) @(negedge clk_i);
        hold_kick = 1'b0;
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_req_q.size() != 0 || in_valid_i || due_status_q.size() != 0)
      @(negedge clk_i);
  endtask

  // Driver: hold a stalled transaction, otherwise offer the next request or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      op_i       <= '0;
      position_i <= '0;
      value_i    <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        due_status_q.push_back(apply_list_request(op_e'(op_i), position_i, value_i));
        items_taken++;
      end
      if (in_valid_i && in_stall_o) begin
        in_valid_i <= 1'b1;
      end else if (pending_req_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_req   = pending_req_q.pop_front();
        op_i       <= next_req.op;
        position_i <= next_req.pos;
        value_i    <= next_req.val;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Count down the long receiver hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_kick) begin
      hold_left <= 400;
    end
  end

  // Monitor: check each status against the oldest prediction, then pick the stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (due_status_q.size() == 0) begin
          report_mismatch($sformatf("status %0d with no request outstanding", status_o));
        end else begin
          want_status = due_status_q.pop_front();
          if (status_o !== want_status)
            report_mismatch($sformatf("result %0d: status %0d, predicted %0d (%s)",
                                      results_seen, status_o, want_status,
                                      want_status.name()));
          status_count[want_status]++;
        end
        results_seen++;
      end
      out_stall_i <= (hold_left != 0) || ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Stimulus
  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      link_mem[i]  = (i == ENTRIES - 1) ? '0 : IDX_W'(i + 1);
      value_mem[i] = '0;
    end
    head_idx      = '0;
    list_len      = 0;
    list_len_peak = 0;
    for (int i = 0; i < 4; i++) status_count[i] = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 34;
    recv_idle_pct = 56;
    // Empty list: nothing to update or delete, insert beyond the end, a no-op
    push_request(OP_DELETE, 0, '0);
    push_request(OP_UPDATE, 0, 32'h1234_5678);
    push_request(OP_INSERT, 1, 32'h0000_0001);
    push_request(OP_NOP, 7, 32'hFFFF_FFFF);
    // Extreme values at head and middle
    push_request(OP_INSERT, 0, 32'h7FFF_FFFF);
    push_request(OP_INSERT, 1, 32'h8000_0000);
    push_request(OP_INSERT, 0, 32'hFFFF_FFFF);
    push_request(OP_UPDATE, 1, 32'h0000_0000);
    push_request(OP_DELETE, 15, '0);
    // Append until every entry is in use, then run out of free entries
    for (int p = 3; p < ENTRIES - 1; p++) push_request(OP_INSERT, p, $urandom);
    push_request(OP_INSERT, 15, 32'h5555_AAAA);
    // Delete one past the tail, the tail itself, and the head
    push_request(OP_DELETE, 15, '0);
    push_request(OP_DELETE, 14, '0);
    push_request(OP_DELETE, 0, '0);
    run_random(450, 1'b1);
    wait_drained();

    send_idle_pct = 56;
    recv_idle_pct = 34;
    run_random(450, 1'b0);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(425, 1'b1);
    wait_drained();
    repeat (50) @(negedge clk_i);

    $display("Ran %0d requests, %0d statuses: ok %0d, past end %0d, no free %0d, no element %0d",
             items_taken, results_seen, status_count[ST_OK], status_count[ST_PAST_END],
             status_count[ST_NO_FREE], status_count[ST_NO_ELEMENT]);
    $display("Longest list %0d of %0d entries, %0d mismatches",
             list_len_peak, ENTRIES - 1, error_count);
    if (error_count == 0 && due_status_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### sim.f
src/sll_pkg.sv
src/sll_link_mem.sv
src/static_linked_list_engine_top.sv
tb/static_linked_list_engine_top_test.sv
